### rtl/audio_fifo_underrun_fader_assert.svh
// Assertion macros used by the checker file.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef AUDIO_FIFO_UNDERRUN_FADER_ASSERT_SVH
`define AUDIO_FIFO_UNDERRUN_FADER_ASSERT_SVH

// Same-cycle implication
`define AFUF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afuf check failed");

// Next-cycle implication
`define AFUF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afuf check failed");

`endif

### rtl/afuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afuf_pkg;

    // Default configuration
    localparam int FIFO_DEPTH_DEF  = 2048;
    localparam int FADE_LEN_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fade weight is Q0.15; one full weight needs one more bit
    localparam int WEIGHT_BITS = 15;
    localparam int WEIGHT_W    = WEIGHT_BITS + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_BITS);

    // Fixed field widths
    localparam int CFG_W   = 11;
    localparam int LEVEL_W = 11;
    localparam int COUNT_W = 32;
    localparam int OP_W    = 2;

    localparam logic [CFG_W-1:0] USABLE_RESET = CFG_W'(2047);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NOP   = 2'd3
    } afuf_op_t;

    // Per-request control and status handed from the FIFO stage onward
    typedef struct packed {
        logic                accepted;
        logic                use_mem;
        logic                upd_held;
        logic [WEIGHT_W-1:0] weight;
        logic                in_underrun;
        logic [LEVEL_W-1:0]  fill_level;
        logic [LEVEL_W-1:0]  free_space;
        logic [COUNT_W-1:0]  played_frames;
        logic [COUNT_W-1:0]  underrun_frames;
    } afuf_s1_t;

endpackage

`default_nettype wire

### rtl/afuf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module afuf_ctrl #(
    parameter int FIFO_DEPTH  = afuf_pkg::FIFO_DEPTH_DEF,
    parameter int FADE_LEN    = afuf_pkg::FADE_LEN_DEF,
    parameter int SAMPLE_BITS = afuf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  afuf_pkg::afuf_op_t                opcode,
    input  logic signed [SAMPLE_BITS-1:0]     in_left,
    input  logic signed [SAMPLE_BITS-1:0]     in_right,
    input  logic                              cfg_we,
    input  logic [afuf_pkg::CFG_W-1:0]        cfg_data,
    output afuf_pkg::afuf_s1_t                s1,
    output logic signed [SAMPLE_BITS-1:0]     rd_left,
    output logic signed [SAMPLE_BITS-1:0]     rd_right
);
    import afuf_pkg::*;

    localparam int AW      = $clog2(FIFO_DEPTH);
    localparam int CAP_MAX = FIFO_DEPTH - 1;
    localparam int CAP_RST = (int'(USABLE_RESET) > CAP_MAX) ? CAP_MAX : int'(USABLE_RESET);
    localparam int POS_W   = $clog2(FADE_LEN + 1);
    localparam int REM_W   = $clog2(FADE_LEN);
    localparam int STEP_Q  = (1 << WEIGHT_BITS) / FADE_LEN;
    localparam int STEP_R  = (1 << WEIGHT_BITS) % FADE_LEN;

    localparam logic [AW-1:0]       LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [POS_W-1:0]    POS_F    = POS_W'(FADE_LEN);
    localparam logic [REM_W:0]      REM_STEP = (REM_W + 1)'(STEP_R);
    localparam logic [REM_W:0]      REM_F    = (REM_W + 1)'(FADE_LEN);
    localparam logic [WEIGHT_W-1:0] W_STEP   = WEIGHT_W'(STEP_Q);

    // FIFO storage and registered read port
    logic [2*SAMPLE_BITS-1:0] mem [FIFO_DEPTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;

    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [AW-1:0]       wr_idx_reg, wr_idx_next;
    logic [AW-1:0]       count_reg, count_next;
    logic [AW-1:0]       cap_reg;
    logic [AW-1:0]       cfg_cap;
    logic                underrun_reg, underrun_next;
    logic                resume_reg, resume_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WEIGHT_W-1:0] wgt_reg, wgt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W-1:0]  played_reg, played_next;
    logic [COUNT_W-1:0]  under_reg, under_next;
    afuf_s1_t            s1_reg, s1_next;

    logic                push_ok, pull_ok;
    logic                phase_restart;
    logic [POS_W-1:0]    base_pos, step_pos;
    logic [WEIGHT_W-1:0] base_w, step_w;
    logic [REM_W-1:0]    base_rem, step_rem;
    logic [REM_W:0]      rem_sum;
    logic                rem_carry;

    // Clamp the written register to 1..FIFO_DEPTH-1
    always_comb
    begin
        if (cfg_data == '0)
            cfg_cap = AW'(1);
        else if (32'(cfg_data) > 32'(CAP_MAX))
            cfg_cap = AW'(CAP_MAX);
        else
            cfg_cap = AW'(32'(cfg_data));
    end

    // A fade or crossfade restarts when the empty/non-empty side of a pull flips
    assign phase_restart = (opcode == OP_PULL) && ((count_reg != '0) == underrun_reg);

    // Advance the shared fade phase: weight = floor(pos * 2^15 / FADE_LEN)
    always_comb
    begin
        if (phase_restart)
        begin
            base_pos = '0;
            base_w   = '0;
            base_rem = '0;
        end
        else
        begin
            base_pos = pos_reg;
            base_w   = wgt_reg;
            base_rem = rem_reg;
        end
        rem_sum   = {1'b0, base_rem} + REM_STEP;
        rem_carry = (rem_sum >= REM_F);
        step_rem  = rem_carry ? REM_W'(rem_sum - REM_F) : REM_W'(rem_sum);
        step_w    = base_w + W_STEP + WEIGHT_W'(rem_carry);
        step_pos  = base_pos + POS_W'(1);
    end

    // Decode the request and work out the next control state
    always_comb
    begin
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        underrun_next = underrun_reg;
        resume_next   = resume_reg;
        pos_next      = pos_reg;
        wgt_next      = wgt_reg;
        rem_next      = rem_reg;
        played_next   = played_reg;
        under_next    = under_reg;
        push_ok       = 1'b0;
        pull_ok       = 1'b0;
        s1_next       = '0;
        s1_next.weight = WEIGHT_ONE;

        unique case (opcode)
            OP_PUSH:
            begin
                if (count_reg < cap_reg)
                begin
                    push_ok          = 1'b1;
                    wr_idx_next      = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + AW'(1);
                    count_next       = count_reg + AW'(1);
                    s1_next.accepted = 1'b1;
                end
            end
            OP_PULL:
            begin
                if (count_reg != '0)
                begin
                    pull_ok          = 1'b1;
                    rd_idx_next      = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + AW'(1);
                    count_next       = count_reg - AW'(1);
                    played_next      = played_reg + COUNT_W'(1);
                    underrun_next    = 1'b0;
                    s1_next.accepted = 1'b1;
                    s1_next.use_mem  = 1'b1;
                    s1_next.upd_held = 1'b1;
                    // Crossfade from the held frame after an underrun
                    if (underrun_reg || resume_reg)
                    begin
                        s1_next.weight = base_w;
                        if (step_pos == POS_F)
                        begin
                            resume_next = 1'b0;
                            pos_next    = '0;
                            wgt_next    = '0;
                            rem_next    = '0;
                        end
                        else
                        begin
                            resume_next = 1'b1;
                            pos_next    = step_pos;
                            wgt_next    = step_w;
                            rem_next    = step_rem;
                        end
                    end
                end
                else
                begin
                    under_next    = under_reg + COUNT_W'(1);
                    underrun_next = 1'b1;
                    // Fade the held frame toward silence, then hold at silence
                    if (base_pos < POS_F)
                    begin
                        s1_next.weight = base_w;
                        pos_next       = step_pos;
                        wgt_next       = step_w;
                        rem_next       = step_rem;
                    end
                    else
                    begin
                        pos_next = base_pos;
                        wgt_next = base_w;
                        rem_next = base_rem;
                    end
                end
            end
            OP_FLUSH:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                count_next  = '0;
            end
            OP_NOP:
            begin
                count_next = count_reg;
            end
        endcase

        // Status after this request
        s1_next.in_underrun     = underrun_next;
        s1_next.fill_level      = LEVEL_W'(32'(count_next));
        s1_next.free_space      = (count_next < cap_reg) ?
                                  LEVEL_W'(32'(cap_reg - count_next)) : '0;
        s1_next.played_frames   = played_next;
        s1_next.underrun_frames = under_next;
    end

    // Hold control state; a register write also empties the FIFO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            count_reg    <= '0;
            cap_reg      <= AW'(CAP_RST);
            underrun_reg <= 1'b0;
            resume_reg   <= 1'b0;
            pos_reg      <= '0;
            wgt_reg      <= '0;
            rem_reg      <= '0;
            played_reg   <= '0;
            under_reg    <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg    <= cfg_cap;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            count_reg    <= count_next;
            underrun_reg <= underrun_next;
            resume_reg   <= resume_next;
            pos_reg      <= pos_next;
            wgt_reg      <= wgt_next;
            rem_reg      <= rem_next;
            played_reg   <= played_next;
            under_reg    <= under_next;
        end
    end

    // Write pushed frames, read the head frame on a pull
    always_ff @(posedge clk)
    begin
        if (accept && push_ok)
            mem[wr_idx_reg] <= {in_right, in_left};
        if (accept && pull_ok)
            rd_data_reg <= mem[rd_idx_reg];
    end

    // Stage register for the lanes and the output merge
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    assign s1       = s1_reg;
    assign rd_left  = $signed(rd_data_reg[SAMPLE_BITS-1:0]);
    assign rd_right = $signed(rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);

endmodule

`default_nettype wire

### rtl/afuf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module afuf_lane #(
    parameter int SAMPLE_BITS = afuf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  afuf_pkg::afuf_s1_t            ctl,
    input  logic signed [SAMPLE_BITS-1:0] rd_sample,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);
    import afuf_pkg::*;

    localparam int PW = SAMPLE_BITS + WEIGHT_W + 2;

    logic signed [SAMPLE_BITS-1:0] held_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic signed [SAMPLE_BITS-1:0] tgt;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [WEIGHT_W:0]      wgt_s;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          step;
    logic signed [PW-1:0]          sum;
    logic signed [SAMPLE_BITS-1:0] mix;

    // out = held + floor((target - held) * w / 2^15); target is zero off the FIFO
    always_comb
    begin
        tgt   = ctl.use_mem ? rd_sample : '0;
        diff  = (SAMPLE_BITS + 1)'(tgt) - (SAMPLE_BITS + 1)'(held_reg);
        wgt_s = $signed({1'b0, ctl.weight});
        prod  = diff * wgt_s;
        step  = prod >>> WEIGHT_BITS;
        sum   = PW'(held_reg) + step;
        mix   = $signed(sum[SAMPLE_BITS-1:0]);
    end

    // Hold the last delivered real frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (adv && ctl.upd_held)
            held_reg <= mix;
    end

    // Register the lane result
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= mix;
    end

    assign out_sample = out_reg;

endmodule

`default_nettype wire

### rtl/audio_fifo_underrun_fader.sv
// An accepted request passes through the request stage register, then the output
// register, before its result is presented.
// Throughput: one request per cycle while results are taken; a stalled result
// blocks the input once the request stage is also full.
// Reset (rst_n low, asynchronous): pointers, fade state, held frame, counters and
// handshakes clear, capacity returns to 2047; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module audio_fifo_underrun_fader #(
    parameter int  FIFO_DEPTH  = afuf_pkg::FIFO_DEPTH_DEF,
    parameter int  FADE_LEN    = afuf_pkg::FADE_LEN_DEF,
    parameter int  SAMPLE_BITS = afuf_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((2 * SAMPLE_BITS + 2 * afuf_pkg::LEVEL_W
                                   + 2 * afuf_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // in_left, in_right
    input  logic [IN_W-1:0]               s_tdata,
    // opcode
    input  logic [afuf_pkg::OP_W-1:0]     s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // out_left, out_right, fill_level, free_space, played_frames, underrun_frames
    output logic [OUT_W-1:0]              m_tdata,
    // accepted, in_underrun
    output logic [1:0]                    m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [afuf_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);
    import afuf_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     accept;
    logic     adv;
    logic     cfg_we;
    afuf_s1_t s1;
    afuf_s1_t out_reg;

    logic signed [SAMPLE_BITS-1:0] rd_left, rd_right;
    logic signed [SAMPLE_BITS-1:0] out_left, out_right;

    // Pipeline handshake: stage one moves on when the output slot frees up
    always_comb
    begin
        adv            = s1_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !s1_valid_reg || adv;
        accept         = s_tvalid && s_tready;
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    afuf_ctrl #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .FADE_LEN    (FADE_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (afuf_op_t'(s_tuser)),
        .in_left  ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_right ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s1       (s1),
        .rd_left  (rd_left),
        .rd_right (rd_right)
    );

    afuf_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (s1),
        .rd_sample  (rd_left),
        .out_sample (out_left)
    );

    afuf_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (s1),
        .rd_sample  (rd_right),
        .out_sample (out_right)
    );

    // Hold status alongside the lane results
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= s1;
    end

    // Merge both lanes and the status into one result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.in_underrun, out_reg.accepted};
    assign m_tdata  = OUT_W'({out_reg.underrun_frames, out_reg.played_frames,
                              out_reg.free_space, out_reg.fill_level,
                              out_right, out_left});

endmodule

`default_nettype wire

### rtl/afuf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "audio_fifo_underrun_fader_assert.svh"

module afuf_checker #(
    parameter int  SAMPLE_BITS = afuf_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W       = ((2 * SAMPLE_BITS + 2 * afuf_pkg::LEVEL_W
                                   + 2 * afuf_pkg::COUNT_W + 7) / 8) * 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic [OUT_W-1:0]           m_tdata,
    input logic [1:0]                 m_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);
    import afuf_pkg::*;

    localparam int FILL_LO = 2 * SAMPLE_BITS;
    localparam int FREE_LO = FILL_LO + LEVEL_W;
    localparam int PLAY_LO = FREE_LO + LEVEL_W;
    localparam int UND_LO  = PLAY_LO + COUNT_W;

    logic                   out_acc;
    logic                   cfg_acc;
    logic [SAMPLE_BITS-1:0] out_left, out_right;
    logic [LEVEL_W-1:0]     fill, free;
    logic [LEVEL_W:0]       level_sum;
    logic [COUNT_W-1:0]     played, under;

    logic                   have_prev_reg;
    logic                   cfg_seen_reg;
    logic [COUNT_W-1:0]     prev_played_reg, prev_under_reg;
    logic [LEVEL_W:0]       prev_sum_reg;

    // Unpack the result ports
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_left  = m_tdata[SAMPLE_BITS-1:0];
    assign out_right = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign fill      = m_tdata[FILL_LO +: LEVEL_W];
    assign free      = m_tdata[FREE_LO +: LEVEL_W];
    assign played    = m_tdata[PLAY_LO +: COUNT_W];
    assign under     = m_tdata[UND_LO +: COUNT_W];
    assign level_sum = {1'b0, fill} + {1'b0, free};

    // Remember the previous delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg   <= 1'b0;
            cfg_seen_reg    <= 1'b0;
            prev_played_reg <= '0;
            prev_under_reg  <= '0;
            prev_sum_reg    <= '0;
        end
        else
        begin
            cfg_seen_reg <= cfg_acc || (cfg_seen_reg && !out_acc);
            if (out_acc)
            begin
                have_prev_reg   <= 1'b1;
                prev_played_reg <= played;
                prev_under_reg  <= under;
                prev_sum_reg    <= level_sum;
            end
        end
    end

    // A stalled result holds
    `AFUF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Without a stored push, a real pull or an underrun, both samples are silent
    `AFUF_ASSERT_IMPL(a_quiet_zero, m_tvalid && !m_tuser[0] && !m_tuser[1],
                      out_left == '0 && out_right == '0)

    // Each request advances at most one of the two frame counters by one
    `AFUF_ASSERT_IMPL(a_count_step, out_acc && have_prev_reg,
                      (played == prev_played_reg && under == prev_under_reg) ||
                      (played == prev_played_reg + 1 && under == prev_under_reg) ||
                      (played == prev_played_reg && under == prev_under_reg + 1))

    // Fill plus free space stays at the capacity until the register is rewritten
    `AFUF_ASSERT_IMPL(a_level_sum, out_acc && have_prev_reg && !cfg_seen_reg,
                      level_sum == prev_sum_reg)

endmodule

bind audio_fifo_underrun_fader afuf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_afuf_checker (.*);

`default_nettype wire

### sim/audio_fifo_underrun_fader_test.sv
`timescale 1ns / 1ps

module audio_fifo_underrun_fader_test;
    import afuf_pkg::*;

    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int DEPTH     = FIFO_DEPTH_DEF;
    localparam int FADE_STEPS = FADE_LEN_DEF;
    localparam int IN_W      = 32;
    localparam int RESULT_W  = 120;
    localparam int LATENCY   = 2;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [LEVEL_W-1:0]         fill;
        logic [LEVEL_W-1:0]         free;
        logic                       underrun;
        logic [COUNT_W-1:0]         played;
        logic [COUNT_W-1:0]         starved;
    } frame_result_t;

    typedef struct {
        bit                         load_cfg;
        logic [CFG_W-1:0]           cfg_value;
        afuf_op_t                   op;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        bit                         typed;
        frame_result_t              want;
    } stim_row_t;

    typedef enum {
        SEG_MIXED,
        SEG_FILL,
        SEG_DRAIN,
        SEG_STARVE,
        SEG_STREAM
    } burst_kind_t;

    localparam frame_result_t BLANK = '{default: '0};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [IN_W-1:0]      s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = OP_NOP;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [RESULT_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    // Shadow state of the fader
    logic signed [SAMPLE_W-1:0] frame_store_left[DEPTH];
    logic signed [SAMPLE_W-1:0] frame_store_right[DEPTH];
    int unsigned                rd_ptr = 0;
    int unsigned                level = 0;
    bit                         underrun_on = 1'b0;
    int unsigned                fade_pos = 0;
    bit                         xfade_on = 1'b0;
    int unsigned                xfade_pos = 0;
    logic signed [SAMPLE_W-1:0] last_left = '0;
    logic signed [SAMPLE_W-1:0] last_right = '0;
    logic [COUNT_W-1:0]         played_cnt = '0;
    logic [COUNT_W-1:0]         starve_cnt = '0;
    logic [CFG_W-1:0]           usable = USABLE_RESET;

    frame_result_t pending_frames[$];
    frame_result_t rx_got;
    frame_result_t rx_want;
    int            errors = 0;
    int            sent = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;

    int phase_idle[5]  = '{0, 50, 0, 31, 31};
    int phase_stall[5] = '{0, 0, 50, 31, 31};
    int phase_budget[5] = '{12, 12, 12, 12, 0};

    stim_row_t directed_rows[21] = '{
        '{0, 0, OP_NOP,   -16'sd1, -16'sd1, 1, '{0, 0, 0, 0, 2047, 0, 0, 0}},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 1, '{0, 0, 0, 0, 2047, 1, 0, 1}},
        '{0, 0, OP_FLUSH, 16'sd0, 16'sd0, 1, '{0, 0, 0, 0, 2047, 1, 0, 1}},
        '{0, 0, OP_PUSH,  S_MAX, S_MIN, 1, '{1, 0, 0, 1, 2046, 1, 0, 1}},
        '{0, 0, OP_PUSH,  S_MIN, S_MAX, 1, '{1, 0, 0, 2, 2045, 1, 0, 1}},
        '{0, 0, OP_PUSH,  16'sd1, -16'sd1, 1, '{1, 0, 0, 3, 2044, 1, 0, 1}},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PUSH,  16'sh1234, -16'sd2, 0, BLANK},
        '{0, 0, OP_FLUSH, 16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_NOP,   16'sh5555, 16'shaaaa, 0, BLANK},
        '{1, 1, OP_PUSH,  S_MAX, S_MAX, 0, BLANK},
        '{0, 0, OP_PUSH,  16'sd0, 16'sd0, 0, BLANK},
        '{0, 0, OP_PULL,  16'sd0, 16'sd0, 0, BLANK},
        '{1, 0, OP_PUSH,  -16'sd1, 16'sd1, 0, BLANK},
        '{0, 0, OP_PUSH,  S_MIN, S_MIN, 0, BLANK},
        '{1, 2047, OP_NOP, 16'sd0, 16'sd0, 0, BLANK}
    };

    audio_fifo_underrun_fader uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #4 clk = ~clk;

    // Clamp the register to the usable FIFO range
    function automatic int unsigned fifo_capacity();
        if (usable == 0)
            return 1;
        if (usable > DEPTH - 1)
            return DEPTH - 1;
        return usable;
    endfunction

    // Q0.15 weight for a fade position
    function automatic longint fade_weight(int unsigned pos);
        int unsigned p;
        p = (pos > FADE_STEPS) ? FADE_STEPS : pos;
        return (longint'(p) << WEIGHT_BITS) / FADE_STEPS;
    endfunction

    // Mix held and fresh samples, floor on the shift
    function automatic logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] held,
                                                          logic signed [SAMPLE_W-1:0] fresh,
                                                          longint w);
        longint mix;
        mix = longint'(held) * ((longint'(1) << WEIGHT_BITS) - w) + longint'(fresh) * w;
        return SAMPLE_W'(mix >>> WEIGHT_BITS);
    endfunction

    // Advance the shadow state by one request and return its result
    function automatic frame_result_t predict_frame(afuf_op_t op,
                                                    logic signed [SAMPLE_W-1:0] in_l,
                                                    logic signed [SAMPLE_W-1:0] in_r);
        frame_result_t              res;
        int unsigned                cap;
        int unsigned                slot;
        logic signed [SAMPLE_W-1:0] fl;
        logic signed [SAMPLE_W-1:0] fr;
        longint                     w;
        res = BLANK;
        cap = fifo_capacity();
        case (op)
            OP_PUSH:
            begin
                if (level < cap)
                begin
                    slot = (rd_ptr + level) % DEPTH;
                    frame_store_left[slot] = in_l;
                    frame_store_right[slot] = in_r;
                    level++;
                    res.accepted = 1'b1;
                end
            end
            OP_PULL:
            begin
                if (level > 0)
                begin
                    fl = frame_store_left[rd_ptr];
                    fr = frame_store_right[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    level--;
                    // Leave underrun and restart the crossfade
                    if (underrun_on)
                    begin
                        underrun_on = 1'b0;
                        fade_pos = 0;
                        xfade_on = 1'b1;
                        xfade_pos = 0;
                    end
                    if (xfade_on)
                    begin
                        w = fade_weight(xfade_pos);
                        fl = blend(last_left, fl, w);
                        fr = blend(last_right, fr, w);
                        xfade_pos++;
                        if (xfade_pos >= FADE_STEPS)
                        begin
                            xfade_on = 1'b0;
                            xfade_pos = 0;
                        end
                    end
                    last_left = fl;
                    last_right = fr;
                    res.left = fl;
                    res.right = fr;
                    played_cnt++;
                    res.accepted = 1'b1;
                end
                else
                begin
                    if (!underrun_on)
                    begin
                        underrun_on = 1'b1;
                        fade_pos = 0;
                    end
                    // Fade the held frame, then hold silence
                    if (fade_pos < FADE_STEPS)
                    begin
                        w = fade_weight(fade_pos);
                        res.left = blend(last_left, '0, w);
                        res.right = blend(last_right, '0, w);
                        fade_pos++;
                    end
                    starve_cnt++;
                end
            end
            OP_FLUSH:
            begin
                rd_ptr = 0;
                level = 0;
            end
            default:
            begin
            end
        endcase
        res.fill = LEVEL_W'(level);
        res.free = LEVEL_W'((level < cap) ? cap - level : 0);
        res.underrun = underrun_on;
        res.played = played_cnt;
        res.starved = starve_cnt;
        return res;
    endfunction

    // Present one request, hold it until taken, then record its expected result
    task automatic send_frame(afuf_op_t op, logic signed [SAMPLE_W-1:0] l,
                              logic signed [SAMPLE_W-1:0] r, bit typed, frame_result_t want);
        frame_result_t model;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model = predict_frame(op, l, r);
        pending_frames.push_back(typed ? want : model);
        sent++;
    endtask

    task automatic send_op(afuf_op_t op, logic signed [SAMPLE_W-1:0] l,
                           logic signed [SAMPLE_W-1:0] r);
        send_frame(op, l, r, 1'b0, BLANK);
    endtask

    // Drain all results, then write the capacity register
    task automatic write_capacity(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        usable = value;
        rd_ptr = 0;
        level = 0;
    endtask

    // Bias toward full scale and zero
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic afuf_op_t random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return OP_PUSH;
        if (pick < 85)
            return OP_PULL;
        if (pick < 93)
            return OP_FLUSH;
        return OP_NOP;
    endfunction

    task automatic run_segment(burst_kind_t kind, int len);
        afuf_op_t op;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SEG_MIXED:  op = random_op();
                SEG_FILL:   op = OP_PUSH;
                SEG_STREAM: op = (i % 2 == 0) ? OP_PUSH : OP_PULL;
                default:    op = OP_PULL;
            endcase
            send_op(op, random_sample(), random_sample());
        end
    endtask

    function automatic int short_len(int unsigned limit);
        return (limit > 48) ? 48 : limit;
    endfunction

    task automatic run_random_bursts(int budget);
        int target;
        target = sent + budget;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_segment(SEG_MIXED, $urandom_range(8, 40));
                4, 5:       run_segment(SEG_FILL, $urandom_range(1, short_len(fifo_capacity() + 3)));
                6, 7:       run_segment(SEG_DRAIN, $urandom_range(1, short_len(fifo_capacity() + 8)));
                8:          run_segment(SEG_STARVE, $urandom_range(4, 30));
                default:    run_segment(SEG_STREAM, $urandom_range(10, 60));
            endcase
        end
    endtask

    // Receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_got.accepted = m_tuser[0];
            rx_got.underrun = m_tuser[1];
            rx_got.left = m_tdata[15:0];
            rx_got.right = m_tdata[31:16];
            rx_got.fill = m_tdata[42:32];
            rx_got.free = m_tdata[53:43];
            rx_got.played = m_tdata[85:54];
            rx_got.starved = m_tdata[117:86];
            if (pending_frames.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                rx_want = pending_frames.pop_front();
                check_field("accepted", rx_want.accepted, rx_got.accepted);
                check_field("out_left", rx_want.left, rx_got.left);
                check_field("out_right", rx_want.right, rx_got.right);
                check_field("fill_level", rx_want.fill, rx_got.fill);
                check_field("free_space", rx_want.free, rx_got.free);
                check_field("in_underrun", rx_want.underrun, rx_got.underrun);
                check_field("played_frames", rx_want.played, rx_got.played);
                check_field("underrun_frames", rx_want.starved, rx_got.starved);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under light idling
        idle_pct = 31;
        stall_pct = 31;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load_cfg)
                write_capacity(directed_rows[i].cfg_value);
            send_frame(directed_rows[i].op, directed_rows[i].left, directed_rows[i].right,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases at several capacities and idling patterns
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_capacity(11'd1);
                1: write_capacity(11'd0);
                2: write_capacity(11'd2047);
                3: write_capacity(CFG_W'($urandom_range(2, 64)));
                default: write_capacity(11'd3);
            endcase
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            run_random_bursts(phase_budget[p]);
            if (p == 4)
            begin
                // Run the fade to silence, then a full crossfade
                run_segment(SEG_STARVE, 258);
                run_segment(SEG_STREAM, 514);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/afuf_pkg.sv
rtl/afuf_ctrl.sv
rtl/afuf_lane.sv
rtl/audio_fifo_underrun_fader.sv
rtl/afuf_checker.sv
sim/audio_fifo_underrun_fader_test.sv
